### hdl/tff_pkg.sv
package tff_pkg;

    // field widths
    localparam int POS_W    = 24;
    localparam int UV_W     = 16;
    localparam int DIR_W    = 16;
    localparam int DIR_FRAC = DIR_W - 2;

    // difference widths
    localparam int PD_W = POS_W + 1;
    localparam int UD_W = UV_W + 1;

    // shared multiplier and accumulator
    localparam int MUL_W  = (PD_W > 31) ? PD_W : 31;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    // block scaling window [2^SC_LO, 2^SC_HI)
    localparam int SC_HI = 30;
    localparam int SC_LO = 29;

    // square root and divider
    localparam int SQ_W     = 2 * SC_HI + 4;
    localparam int SQ_STEPS = SC_HI + 2;
    localparam int LEN_W    = SC_HI + 1;
    localparam int DIV_W    = LEN_W + DIR_FRAC;
    localparam int DCNT_W   = $clog2(DIR_FRAC + 1);

    // vertex slots and queue
    localparam logic [1:0] SLOT_LAST = 2'd2;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one triangle word: [vertex][axis]
    typedef struct packed {
        logic [2:0][2:0][POS_W-1:0] pos;
        logic [2:0][1:0][UV_W-1:0]  uv;
        logic [2:0][2:0][DIR_W-1:0] nrm;
    } tri_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET,
        ST_TRAW,
        ST_TSCALE,
        ST_VSTART,
        ST_CROSS_B,
        ST_BSCALE,
        ST_CROSS_T,
        ST_T2SCALE,
        ST_LEN2,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

### hdl/tff_front.sv
module tff_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_y,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_z,
    input  logic signed [tff_pkg::UV_W-1:0]   s_tex_s,
    input  logic signed [tff_pkg::UV_W-1:0]   s_tex_t,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_x,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_y,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_z,
    output logic                              push_valid,
    input  logic                              push_ready,
    output tff_pkg::tri_t                     push_data
);

    logic [1:0]    cnt_reg;
    tff_pkg::tri_t hold_reg;
    logic          accept;
    logic          is_last;

    // third vertex closes a triangle and needs queue space
    assign is_last    = (cnt_reg == tff_pkg::SLOT_LAST);
    assign s_ready    = !is_last || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && is_last;

    always_comb begin
        push_data = hold_reg;
        push_data.pos[tff_pkg::SLOT_LAST] = {s_pos_z, s_pos_y, s_pos_x};
        push_data.uv[tff_pkg::SLOT_LAST]  = {s_tex_t, s_tex_s};
        push_data.nrm[tff_pkg::SLOT_LAST] = {s_norm_z, s_norm_y, s_norm_x};
    end

    // vertex counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= is_last ? 2'd0 : cnt_reg + 2'd1;
        end
    end

    // hold first two vertices
    always_ff @(posedge aclk) begin
        if (accept && !is_last) begin
            hold_reg.pos[cnt_reg] <= {s_pos_z, s_pos_y, s_pos_x};
            hold_reg.uv[cnt_reg]  <= {s_tex_t, s_tex_s};
            hold_reg.nrm[cnt_reg] <= {s_norm_z, s_norm_y, s_norm_x};
        end
    end

endmodule

### hdl/tff_queue.sv
module tff_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  tff_pkg::tri_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tff_pkg::tri_t pop_data
);

    tff_pkg::tri_t               mem_reg [tff_pkg::QDEPTH];
    logic [tff_pkg::QPTR_W-1:0]  wr_reg;
    logic [tff_pkg::QPTR_W-1:0]  rd_reg;
    logic [tff_pkg::QPTR_W:0]    count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != (tff_pkg::QPTR_W + 1)'(tff_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == tff_pkg::QPTR_W'(tff_pkg::QDEPTH - 1))
                        ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == tff_pkg::QPTR_W'(tff_pkg::QDEPTH - 1))
                        ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

### hdl/tff_back.sv
module tff_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  tff_pkg::tri_t                     pop_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_x,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_y,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_z,
    output logic [1:0]                        m_vertex_slot,
    output logic                              m_degenerate,
    output logic                              m_last
);

    tff_pkg::back_state_t state_reg, state_next;
    logic [1:0]  comp_reg, comp_next;
    logic [1:0]  term_reg, term_next;
    logic        phase_reg, phase_next;
    logic [1:0]  vtx_reg, vtx_next;

    logic signed [tff_pkg::PD_W-1:0]  ab_reg [3], ab_next [3];
    logic signed [tff_pkg::PD_W-1:0]  ac_reg [3], ac_next [3];
    logic signed [tff_pkg::UD_W-1:0]  dsab_reg, dsab_next, dtab_reg, dtab_next;
    logic signed [tff_pkg::UD_W-1:0]  dsac_reg, dsac_next, dtac_reg, dtac_next;
    logic signed [tff_pkg::DIR_W-1:0] nrm_reg [3][3], nrm_next [3][3];

    logic detneg_reg, detneg_next;
    logic triok_reg, triok_next;
    logic vok_reg, vok_next;

    logic signed [tff_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [tff_pkg::ACC_W-1:0]  acc_reg, acc_next;

    logic [tff_pkg::ACC_W-1:0] sc_mag_reg [3], sc_mag_next [3];
    logic                      sc_neg_reg [3], sc_neg_next [3];
    logic [tff_pkg::ACC_W-1:0] sc_top_reg, sc_top_next;

    logic signed [tff_pkg::MUL_W-1:0] ts_reg [3], ts_next [3];
    logic signed [tff_pkg::MUL_W-1:0] bs_reg [3], bs_next [3];

    logic [tff_pkg::SQ_W-1:0]   sq_x_reg, sq_x_next, sq_r_reg, sq_r_next;
    logic [tff_pkg::SQ_W-1:0]   sq_bit_reg, sq_bit_next;
    logic [tff_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [tff_pkg::DIV_W-1:0]  div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [tff_pkg::DIR_W-1:0]  div_q_reg, div_q_next;
    logic [tff_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic signed [tff_pkg::DIR_W-1:0] u_reg [3], u_next [3];

    logic                             m_valid_reg, m_valid_next;
    logic signed [tff_pkg::DIR_W-1:0] m_tan_reg [3], m_tan_next [3];
    logic [1:0]                       m_slot_reg, m_slot_next;
    logic                             m_deg_reg, m_deg_next;
    logic                             m_last_reg, m_last_next;

    // combinational helpers
    logic signed [tff_pkg::MUL_W-1:0]  sc_val [3];
    logic signed [tff_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [tff_pkg::PROD_W-1:0] mul_a_x, mul_b_x;
    logic signed [tff_pkg::ACC_W-1:0]  acc_new;
    logic [tff_pkg::ACC_W-1:0]         acc_mag;
    logic [1:0]                        i1, i2;
    logic                              last_term;
    logic [tff_pkg::SQ_W-1:0]          sq_trial;
    logic [tff_pkg::SQ_W-1:0]          sq_r_new;
    logic                              out_free;
    logic signed [tff_pkg::MUL_W-1:0]  sc_tmp [3];

    assign pop_ready     = (state_reg == tff_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_tan_x       = m_tan_reg[0];
    assign m_tan_y       = m_tan_reg[1];
    assign m_tan_z       = m_tan_reg[2];
    assign m_vertex_slot = m_slot_reg;
    assign m_degenerate  = m_deg_reg;
    assign m_last        = m_last_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // scaled vector components as signed values
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sc_tmp[i] = tff_pkg::MUL_W'(sc_mag_reg[i][tff_pkg::SC_HI-1:0]);
            sc_val[i] = sc_neg_reg[i] ? -sc_tmp[i] : sc_tmp[i];
        end
    end

    // cross product index rotation
    always_comb begin
        case (comp_reg)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            tff_pkg::ST_DET: begin
                mul_a = (term_reg == 2'd0) ? tff_pkg::MUL_W'(dsac_reg)
                                           : tff_pkg::MUL_W'(dsab_reg);
                mul_b = (term_reg == 2'd0) ? tff_pkg::MUL_W'(dtab_reg)
                                           : tff_pkg::MUL_W'(dtac_reg);
            end
            tff_pkg::ST_TRAW: begin
                mul_a = (term_reg == 2'd0) ? tff_pkg::MUL_W'(ac_reg[comp_reg])
                                           : tff_pkg::MUL_W'(ab_reg[comp_reg]);
                mul_b = (term_reg == 2'd0) ? tff_pkg::MUL_W'(dtab_reg)
                                           : tff_pkg::MUL_W'(dtac_reg);
            end
            tff_pkg::ST_CROSS_B: begin
                mul_a = (term_reg == 2'd0) ? tff_pkg::MUL_W'(nrm_reg[vtx_reg][i1])
                                           : tff_pkg::MUL_W'(nrm_reg[vtx_reg][i2]);
                mul_b = (term_reg == 2'd0) ? ts_reg[i2] : ts_reg[i1];
            end
            tff_pkg::ST_CROSS_T: begin
                mul_a = (term_reg == 2'd0) ? bs_reg[i1] : bs_reg[i2];
                mul_b = (term_reg == 2'd0) ? tff_pkg::MUL_W'(nrm_reg[vtx_reg][i2])
                                           : tff_pkg::MUL_W'(nrm_reg[vtx_reg][i1]);
            end
            tff_pkg::ST_LEN2: begin
                mul_a = tff_pkg::MUL_W'(sc_mag_reg[term_reg][tff_pkg::SC_HI-1:0]);
                mul_b = tff_pkg::MUL_W'(sc_mag_reg[term_reg][tff_pkg::SC_HI-1:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_a_x = tff_pkg::PROD_W'(mul_a);
        mul_b_x = tff_pkg::PROD_W'(mul_b);
    end

    // accumulate step and square root trial
    always_comb begin
        last_term = (state_reg == tff_pkg::ST_LEN2) ? (term_reg == 2'd2)
                                                    : (term_reg == 2'd1);
        if (state_reg == tff_pkg::ST_LEN2 || term_reg == 2'd0) begin
            acc_new = ((term_reg == 2'd0) ? '0 : acc_reg) + tff_pkg::ACC_W'(prod_reg);
        end else begin
            acc_new = acc_reg - tff_pkg::ACC_W'(prod_reg);
        end
        acc_mag  = acc_new[tff_pkg::ACC_W-1] ? tff_pkg::ACC_W'(-acc_new)
                                             : tff_pkg::ACC_W'(acc_new);
        sq_trial = sq_r_reg + sq_bit_reg;
        sq_r_new = (sq_x_reg >= sq_trial) ? ((sq_r_reg >> 1) + sq_bit_reg)
                                          : (sq_r_reg >> 1);
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        comp_next    = comp_reg;
        term_next    = term_reg;
        phase_next   = phase_reg;
        vtx_next     = vtx_reg;
        dsab_next    = dsab_reg;
        dtab_next    = dtab_reg;
        dsac_next    = dsac_reg;
        dtac_next    = dtac_reg;
        detneg_next  = detneg_reg;
        triok_next   = triok_reg;
        vok_next     = vok_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        sc_top_next  = sc_top_reg;
        sq_x_next    = sq_x_reg;
        sq_r_next    = sq_r_reg;
        sq_bit_next  = sq_bit_reg;
        len_next     = len_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_q_next   = div_q_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg;
        m_slot_next  = m_slot_reg;
        m_deg_next   = m_deg_reg;
        m_last_next  = m_last_reg;
        for (int i = 0; i < 3; i++) begin
            ab_next[i]     = ab_reg[i];
            ac_next[i]     = ac_reg[i];
            sc_mag_next[i] = sc_mag_reg[i];
            sc_neg_next[i] = sc_neg_reg[i];
            ts_next[i]     = ts_reg[i];
            bs_next[i]     = bs_reg[i];
            u_next[i]      = u_reg[i];
            m_tan_next[i]  = m_tan_reg[i];
            for (int j = 0; j < 3; j++) begin
                nrm_next[i][j] = nrm_reg[i][j];
            end
        end

        // output word taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tff_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    for (int a = 0; a < 3; a++) begin
                        ab_next[a] = tff_pkg::PD_W'($signed(pop_data.pos[1][a]))
                                   - tff_pkg::PD_W'($signed(pop_data.pos[0][a]));
                        ac_next[a] = tff_pkg::PD_W'($signed(pop_data.pos[2][a]))
                                   - tff_pkg::PD_W'($signed(pop_data.pos[0][a]));
                        for (int v = 0; v < 3; v++) begin
                            nrm_next[v][a] = $signed(pop_data.nrm[v][a]);
                        end
                    end
                    dsab_next = tff_pkg::UD_W'($signed(pop_data.uv[1][0]))
                              - tff_pkg::UD_W'($signed(pop_data.uv[0][0]));
                    dtab_next = tff_pkg::UD_W'($signed(pop_data.uv[1][1]))
                              - tff_pkg::UD_W'($signed(pop_data.uv[0][1]));
                    dsac_next = tff_pkg::UD_W'($signed(pop_data.uv[2][0]))
                              - tff_pkg::UD_W'($signed(pop_data.uv[0][0]));
                    dtac_next = tff_pkg::UD_W'($signed(pop_data.uv[2][1]))
                              - tff_pkg::UD_W'($signed(pop_data.uv[0][1]));
                    comp_next  = '0;
                    term_next  = '0;
                    phase_next = 1'b0;
                    state_next = tff_pkg::ST_DET;
                end
            end

            tff_pkg::ST_DET, tff_pkg::ST_TRAW, tff_pkg::ST_CROSS_B,
            tff_pkg::ST_CROSS_T, tff_pkg::ST_LEN2: begin
                if (!phase_reg) begin
                    prod_next  = mul_a_x * mul_b_x;
                    phase_next = 1'b1;
                end else begin
                    acc_next   = acc_new;
                    phase_next = 1'b0;
                    if (!last_term) begin
                        term_next = term_reg + 2'd1;
                    end else begin
                        term_next = '0;
                        case (state_reg)
                            tff_pkg::ST_DET: begin
                                detneg_next = acc_new[tff_pkg::ACC_W-1];
                                if (acc_new == '0) begin
                                    triok_next = 1'b0;
                                    vtx_next   = '0;
                                    state_next = tff_pkg::ST_VSTART;
                                end else begin
                                    triok_next = 1'b1;
                                    comp_next  = '0;
                                    state_next = tff_pkg::ST_TRAW;
                                end
                            end
                            tff_pkg::ST_LEN2: begin
                                sq_x_next   = tff_pkg::SQ_W'(acc_new);
                                sq_r_next   = '0;
                                sq_bit_next = tff_pkg::SQ_W'(1)
                                            << (2 * (tff_pkg::SQ_STEPS - 1));
                                state_next  = tff_pkg::ST_SQRT;
                            end
                            default: begin
                                // component of a vector into the scaler
                                sc_mag_next[comp_reg] = acc_mag;
                                sc_neg_next[comp_reg] = (state_reg == tff_pkg::ST_TRAW)
                                    ? (acc_new[tff_pkg::ACC_W-1] ^ detneg_reg)
                                    : acc_new[tff_pkg::ACC_W-1];
                                if (comp_reg == 2'd0 || acc_mag > sc_top_reg) begin
                                    sc_top_next = acc_mag;
                                end
                                if (comp_reg == 2'd2) begin
                                    comp_next = '0;
                                    case (state_reg)
                                        tff_pkg::ST_TRAW:
                                            state_next = tff_pkg::ST_TSCALE;
                                        tff_pkg::ST_CROSS_B:
                                            state_next = tff_pkg::ST_BSCALE;
                                        default:
                                            state_next = tff_pkg::ST_T2SCALE;
                                    endcase
                                end else begin
                                    comp_next = comp_reg + 2'd1;
                                end
                            end
                        endcase
                    end
                end
            end

            tff_pkg::ST_TSCALE, tff_pkg::ST_BSCALE, tff_pkg::ST_T2SCALE: begin
                if (sc_top_reg == '0) begin
                    // zero-length vector
                    if (state_reg == tff_pkg::ST_TSCALE) begin
                        triok_next = 1'b0;
                        vtx_next   = '0;
                        state_next = tff_pkg::ST_VSTART;
                    end else begin
                        vok_next   = 1'b0;
                        for (int i = 0; i < 3; i++) u_next[i] = '0;
                        state_next = tff_pkg::ST_OUT;
                    end
                end else if (sc_top_reg[tff_pkg::ACC_W-1:tff_pkg::SC_HI] != '0) begin
                    sc_top_next = sc_top_reg >> 1;
                    for (int i = 0; i < 3; i++) sc_mag_next[i] = sc_mag_reg[i] >> 1;
                end else if (sc_top_reg[tff_pkg::SC_HI-1:tff_pkg::SC_LO] == '0) begin
                    sc_top_next = sc_top_reg << 1;
                    for (int i = 0; i < 3; i++) sc_mag_next[i] = sc_mag_reg[i] << 1;
                end else begin
                    case (state_reg)
                        tff_pkg::ST_TSCALE: begin
                            for (int i = 0; i < 3; i++) ts_next[i] = sc_val[i];
                            vtx_next   = '0;
                            state_next = tff_pkg::ST_VSTART;
                        end
                        tff_pkg::ST_BSCALE: begin
                            for (int i = 0; i < 3; i++) bs_next[i] = sc_val[i];
                            comp_next  = '0;
                            term_next  = '0;
                            phase_next = 1'b0;
                            state_next = tff_pkg::ST_CROSS_T;
                        end
                        default: begin
                            term_next  = '0;
                            phase_next = 1'b0;
                            state_next = tff_pkg::ST_LEN2;
                        end
                    endcase
                end
            end

            tff_pkg::ST_VSTART: begin
                if (!triok_reg) begin
                    vok_next   = 1'b0;
                    for (int i = 0; i < 3; i++) u_next[i] = '0;
                    state_next = tff_pkg::ST_OUT;
                end else begin
                    vok_next   = 1'b1;
                    comp_next  = '0;
                    term_next  = '0;
                    phase_next = 1'b0;
                    state_next = tff_pkg::ST_CROSS_B;
                end
            end

            // one result bit per cycle
            tff_pkg::ST_SQRT: begin
                if (sq_x_reg >= sq_trial) begin
                    sq_x_next = sq_x_reg - sq_trial;
                end
                sq_r_next   = sq_r_new;
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg == tff_pkg::SQ_W'(1)) begin
                    len_next   = tff_pkg::LEN_W'(sq_r_new);
                    comp_next  = '0;
                    phase_next = 1'b0;
                    state_next = tff_pkg::ST_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            tff_pkg::ST_DIV: begin
                if (!phase_reg) begin
                    div_rem_next = (tff_pkg::DIV_W'(sc_mag_reg[comp_reg][tff_pkg::SC_HI-1:0])
                                    << tff_pkg::DIR_FRAC)
                                 + tff_pkg::DIV_W'(len_reg >> 1);
                    div_den_next = tff_pkg::DIV_W'(len_reg) << tff_pkg::DIR_FRAC;
                    div_q_next   = '0;
                    div_cnt_next = tff_pkg::DCNT_W'(tff_pkg::DIR_FRAC);
                    phase_next   = 1'b1;
                end else begin
                    if (div_rem_reg >= div_den_reg) begin
                        div_rem_next = div_rem_reg - div_den_reg;
                        div_q_next   = {div_q_reg[tff_pkg::DIR_W-2:0], 1'b1};
                    end else begin
                        div_q_next   = {div_q_reg[tff_pkg::DIR_W-2:0], 1'b0};
                    end
                    div_den_next = div_den_reg >> 1;
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0) begin
                        u_next[comp_reg] = sc_neg_reg[comp_reg] ? -$signed(div_q_next)
                                                                : $signed(div_q_next);
                        phase_next = 1'b0;
                        if (comp_reg == 2'd2) begin
                            state_next = tff_pkg::ST_OUT;
                        end else begin
                            comp_next = comp_reg + 2'd1;
                        end
                    end
                end
            end

            tff_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    for (int i = 0; i < 3; i++) m_tan_next[i] = u_reg[i];
                    m_slot_next = vtx_reg;
                    m_deg_next  = !vok_reg;
                    m_last_next = (vtx_reg == tff_pkg::SLOT_LAST);
                    if (vtx_reg == tff_pkg::SLOT_LAST) begin
                        state_next = tff_pkg::ST_IDLE;
                    end else begin
                        vtx_next   = vtx_reg + 2'd1;
                        state_next = tff_pkg::ST_VSTART;
                    end
                end
            end

            default: begin
                state_next = tff_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tff_pkg::ST_IDLE;
            comp_reg    <= '0;
            term_reg    <= '0;
            phase_reg   <= 1'b0;
            vtx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            comp_reg    <= comp_next;
            term_reg    <= term_next;
            phase_reg   <= phase_next;
            vtx_reg     <= vtx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dsab_reg    <= dsab_next;
        dtab_reg    <= dtab_next;
        dsac_reg    <= dsac_next;
        dtac_reg    <= dtac_next;
        detneg_reg  <= detneg_next;
        triok_reg   <= triok_next;
        vok_reg     <= vok_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sc_top_reg  <= sc_top_next;
        sq_x_reg    <= sq_x_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
        len_reg     <= len_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        m_slot_reg  <= m_slot_next;
        m_deg_reg   <= m_deg_next;
        m_last_reg  <= m_last_next;
        for (int i = 0; i < 3; i++) begin
            ab_reg[i]     <= ab_next[i];
            ac_reg[i]     <= ac_next[i];
            sc_mag_reg[i] <= sc_mag_next[i];
            sc_neg_reg[i] <= sc_neg_next[i];
            ts_reg[i]     <= ts_next[i];
            bs_reg[i]     <= bs_next[i];
            u_reg[i]      <= u_next[i];
            m_tan_reg[i]  <= m_tan_next[i];
            for (int j = 0; j < 3; j++) begin
                nrm_reg[i][j] <= nrm_next[i][j];
            end
        end
    end

endmodule

### hdl/triangle_tangent_frame.sv
// triangle_tangent_frame: vertices arrive one word at a time and are grouped
// three to a triangle; after the third vertex the block emits three tangent
// words (slots 0, 1, 2, last on slot 2) in Q1.14. The first two vertices of a
// triangle are always accepted; the third is taken as soon as the two-entry
// triangle queue has room. The back end works on one triangle at a time
// with one shared multiplier, a one-bit-per-cycle normalizing shifter, a
// 32-step square root and a 15-step restoring divider per component. It
// waits while the result side stalls. A zero UV determinant or zero-length
// vector gives a zero tangent with degenerate set.
module triangle_tangent_frame (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_y,
    input  logic signed [tff_pkg::POS_W-1:0]  s_pos_z,
    input  logic signed [tff_pkg::UV_W-1:0]   s_tex_s,
    input  logic signed [tff_pkg::UV_W-1:0]   s_tex_t,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_x,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_y,
    input  logic signed [tff_pkg::DIR_W-1:0]  s_norm_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_x,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_y,
    output logic signed [tff_pkg::DIR_W-1:0]  m_tan_z,
    output logic [1:0]                        m_vertex_slot,
    output logic                              m_degenerate,
    output logic                              m_last
);

    logic          push_valid, push_ready;
    tff_pkg::tri_t push_data;
    logic          pop_valid, pop_ready;
    tff_pkg::tri_t pop_data;

    // vertex grouping
    tff_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_tex_s    (s_tex_s),
        .s_tex_t    (s_tex_t),
        .s_norm_x   (s_norm_x),
        .s_norm_y   (s_norm_y),
        .s_norm_z   (s_norm_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // triangle queue
    tff_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // tangent datapath
    tff_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tan_x       (m_tan_x),
        .m_tan_y       (m_tan_y),
        .m_tan_z       (m_tan_z),
        .m_vertex_slot (m_vertex_slot),
        .m_degenerate  (m_degenerate),
        .m_last        (m_last)
    );

`ifndef SYNTHESIS
    // last marks slot two and nothing else
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_vertex_slot == tff_pkg::SLOT_LAST)))
        else $error("last flag does not match vertex slot");

    // degenerate words carry a zero tangent
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_tan_x == '0 && m_tan_y == '0 && m_tan_z == '0))
        else $error("degenerate word with nonzero tangent");

    // slot after a taken non-last word advances by one
    a_slot_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) ##1 m_valid |->
            (m_vertex_slot == $past(m_vertex_slot) + 2'd1))
        else $error("vertex slot out of sequence");
`endif

endmodule
